FILE: rtl/cde_pkg.sv
// shared types and constants of the circular deque
package cde_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH_LEFT  = 2'd0,
    OP_POP_LEFT   = 2'd1,
    OP_PUSH_RIGHT = 2'd2,
    OP_POP_RIGHT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cell strobes from the index logic
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cell_ctl_t;

endpackage

FILE: rtl/cde_in_if.sv
// operation channel of the circular deque
interface cde_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic [cde_pkg::FIELD_BITS-1:0]   push_word;

  modport source (output valid, output operation, output push_word, input ready);
  modport sink   (input valid, input operation, input push_word, output ready);
endinterface

FILE: rtl/cde_out_if.sv
// result channel of the circular deque
interface cde_out_if;
  logic                             valid;
  logic                             ready;
  logic [cde_pkg::FIELD_BITS-1:0]   pop_word;
  logic [1:0]                       status;
  logic                             is_empty;
  logic                             is_full;

  modport source (output valid, output pop_word, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input pop_word, input status, input is_empty,
                  input is_full, output ready);
endinterface

FILE: rtl/circular_deque.sv
// top level of the circular deque: index control, cell row and result register
//
//   channel  | dir | handshake      | word
//   ---------+-----+----------------+------------------------------------------
//   in_ch    | in  | valid / ready  | operation, push_word
//   out_ch   | out | valid / ready  | pop_word, status, is_empty, is_full
//   cfg      | in  | cfg_wr_en      | cfg_wr_data (capacity)
//
// one word per cycle: an operation is done in the cycle it is accepted and its
// result is registered; the cell row read chain and the index step set the path
// a new word is taken while the previous result waits, as long as out_ch is taken
// reset (rst_n, synchronous) empties the deque, zeroes both indices and sets
// capacity to 16; the cell contents are not cleared
// a stalled result holds in_ch.ready low until it is taken
module circular_deque #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cde_pkg::CAP_W-1:0]     cfg_wr_data,
  cde_in_if.sink                        in_ch,
  cde_out_if.source                     out_ch
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // wide enough for the capacity register and for DEPTH itself
  localparam int unsigned CW = ((IDX_W + 1) > cde_pkg::CAP_W) ? (IDX_W + 1) : cde_pkg::CAP_W;

  // capacity register
  logic [cde_pkg::CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= cde_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // highest index in use: zero capacity acts as one, above DEPTH acts as DEPTH
  logic [CW-1:0]    cap_w;
  logic [IDX_W-1:0] top;

  always_comb begin
    cap_w = CW'(cap_r);
    if (cap_r == '0) begin
      top = '0;
    end else if (cap_w > CW'(DEPTH)) begin
      top = IDX_W'(DEPTH - 1);
    end else begin
      top = IDX_W'(cap_w - CW'(1));
    end
  end

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [IDX_W-1:0] lim);
    return (idx >= lim) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] lim);
    return (idx == '0) ? lim : idx - IDX_W'(1);
  endfunction

  // deque state
  logic [IDX_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] right_r, right_nxt;
  logic             empty_r, empty_nxt;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic [cde_pkg::FIELD_BITS-1:0] pop_word_r, pop_word_nxt;
  cde_pkg::status_t               status_r, status_nxt;
  logic                           is_empty_r;
  logic                           is_full_r, is_full_nxt;

  logic accept;
  logic full_now;
  logic is_push;
  logic at_left;

  // cell row controls
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] chain [DEPTH+1];

  cde_pkg::op_t op;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = cde_pkg::op_t'(in_ch.operation);
  assign is_push     = (op == cde_pkg::OP_PUSH_LEFT) || (op == cde_pkg::OP_PUSH_RIGHT);
  assign at_left     = (op == cde_pkg::OP_PUSH_LEFT) || (op == cde_pkg::OP_POP_LEFT);
  assign full_now    = !empty_r && (step_up(right_r, top) == left_r);
  assign wr_word     = WORD_BITS'(in_ch.push_word);
  assign rd_idx      = at_left ? left_r : right_r;

  // operation decode and next state
  always_comb begin
    left_nxt      = left_r;
    right_nxt     = right_r;
    empty_nxt     = empty_r;
    wr_en         = 1'b0;
    wr_idx        = '0;
    status_nxt    = cde_pkg::ST_DONE;
    pop_word_nxt  = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (accept) begin
      out_valid_nxt = 1'b1;
      if (is_push) begin
        priority if (full_now) begin
          status_nxt = cde_pkg::ST_FULL;
        end else if (empty_r) begin
          // first word always lands in entry zero
          left_nxt  = '0;
          right_nxt = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_idx    = '0;
        end else if (at_left) begin
          left_nxt = step_down(left_r, top);
          wr_en    = 1'b1;
          wr_idx   = left_nxt;
        end else begin
          right_nxt = step_up(right_r, top);
          wr_en     = 1'b1;
          wr_idx    = right_nxt;
        end
      end else begin
        priority if (empty_r) begin
          status_nxt = cde_pkg::ST_EMPTY;
        end else begin
          pop_word_nxt = cde_pkg::FIELD_BITS'(chain[DEPTH]);
          // last word out: indices stay where they are
          priority if (left_r == right_r) begin
            empty_nxt = 1'b1;
          end else if (at_left) begin
            left_nxt = step_up(left_r, top);
          end else begin
            right_nxt = step_down(right_r, top);
          end
        end
      end
    end

    is_full_nxt = !empty_nxt && (step_up(right_nxt, top) == left_nxt);
  end

  // row of cells, read word passed from cell to cell
  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cde_pkg::cell_ctl_t ctl;

    assign ctl.wr_en = wr_en && (wr_idx == IDX_W'(i));
    assign ctl.rd_en = (rd_idx == IDX_W'(i));

    cde_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr_word   (wr_word),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      right_r     <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_word_r <= pop_word_nxt;
      status_r   <= status_nxt;
      is_empty_r <= empty_nxt;
      is_full_r  <= is_full_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.pop_word = pop_word_r;
  assign out_ch.status   = status_r;
  assign out_ch.is_empty = is_empty_r;
  assign out_ch.is_full  = is_full_r;

  // every accepted word leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("no result after accepted word");

  // a refused push leaves the deque untouched
  a_full_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_push && full_now) |=>
      ($stable(left_r) && $stable(right_r) && $stable(empty_r)))
    else $error("refused push changed deque state");

  // a pop from an empty deque answers zero and the empty code
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_push && empty_r) |=>
      (out_ch.pop_word == '0 && out_ch.status == cde_pkg::ST_EMPTY && out_ch.is_empty))
    else $error("bad result for pop from empty deque");

  // full and empty never reported together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_empty && out_ch.is_full))
    else $error("result reports both empty and full");

endmodule

FILE: rtl/cde_cell.sv
// one storage cell of the deque: holds a word and passes the read chain on
module cde_cell #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk,
  input  cde_pkg::cell_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  wr_word,
  input  logic [WORD_BITS-1:0]  chain_in,
  output logic [WORD_BITS-1:0]  chain_out
);

  logic [WORD_BITS-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      word_r <= wr_word;
    end
  end

  // selected cell ors its word into the word travelling down the row
  assign chain_out = ctl.rd_en ? (chain_in | word_r) : chain_in;

endmodule

FILE: tb/cde_checker.sv
// checker of the circular deque: mirrors the deque, predicts each result word and compares it
`timescale 1ns / 1ps
module cde_checker
  import cde_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  cde_in_if                in_mon,
  cde_out_if               out_mon,
  output int               mismatches,
  output int               owed,
  output int               words_checked,
  output int               words_popped,
  output int               full_refusals,
  output int               empty_refusals
);

  typedef struct packed {
    logic [FIELD_BITS-1:0] pop_word;
    status_t               status;
    logic                  is_empty;
    logic                  is_full;
  } deque_result_t;

  logic [FIELD_BITS-1:0] cells [DEPTH];
  logic [CAP_W-1:0]      capacity;
  int unsigned           left_at;
  int unsigned           right_at;
  bit                    held_none;
  deque_result_t         owed_results [$];

  // capacity as the index logic sees it: zero acts as one, above depth acts as depth
  function automatic int unsigned lanes();
    if (capacity == '0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return capacity;
  endfunction

  function automatic int unsigned step_up(int unsigned idx);
    return (idx >= lanes() - 1) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned idx);
    return (idx == 0) ? lanes() - 1 : idx - 1;
  endfunction

  function automatic bit full_now();
    return !held_none && (step_up(right_at) == left_at);
  endfunction

  function automatic deque_result_t apply_op(op_t op, logic [FIELD_BITS-1:0] word);
    deque_result_t r;
    bit            pushing;
    bit            left_side;
    r         = '0;
    r.status  = ST_DONE;
    pushing   = (op == OP_PUSH_LEFT) || (op == OP_PUSH_RIGHT);
    left_side = (op == OP_PUSH_LEFT) || (op == OP_POP_LEFT);
    if (pushing) begin
      if (full_now()) begin
        r.status = ST_FULL;
      end else if (held_none) begin
        left_at   = 0;
        right_at  = 0;
        held_none = 1'b0;
        cells[0]  = word;
      end else if (left_side) begin
        left_at        = step_down(left_at);
        cells[left_at] = word;
      end else begin
        right_at        = step_up(right_at);
        cells[right_at] = word;
      end
    end else if (held_none) begin
      r.status = ST_EMPTY;
    end else begin
      r.pop_word = cells[left_side ? left_at : right_at];
      if (left_at == right_at) held_none = 1'b1;
      else if (left_side) left_at = step_up(left_at);
      else right_at = step_down(right_at);
    end
    r.is_empty = held_none;
    r.is_full  = full_now();
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_BITS-1:0] got,
                                 logic [FIELD_BITS-1:0] want);
    $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      capacity       = CAP_RESET;
      left_at        = 0;
      right_at       = 0;
      held_none      = 1'b1;
      mismatches     = 0;
      words_checked  = 0;
      words_popped   = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      owed_results.delete();
    end else begin
      // the result leaving now belongs to an older word than any taken at this edge
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result word with nothing owed, pop_word", out_mon.pop_word, '0);
        end else begin
          want = owed_results.pop_front();
          words_checked++;
          if (out_mon.pop_word !== want.pop_word)
            report_mismatch("pop_word", out_mon.pop_word, want.pop_word);
          if (out_mon.status !== want.status)
            report_mismatch("status", FIELD_BITS'(out_mon.status), FIELD_BITS'(want.status));
          if (out_mon.is_empty !== want.is_empty)
            report_mismatch("is_empty", FIELD_BITS'(out_mon.is_empty),
                            FIELD_BITS'(want.is_empty));
          if (out_mon.is_full !== want.is_full)
            report_mismatch("is_full", FIELD_BITS'(out_mon.is_full), FIELD_BITS'(want.is_full));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = apply_op(op_t'(in_mon.operation), in_mon.push_word);
        case (want.status)
          ST_FULL:  full_refusals++;
          ST_EMPTY: empty_refusals++;
          default:  if (op_t'(in_mon.operation) == OP_POP_LEFT ||
                        op_t'(in_mon.operation) == OP_POP_RIGHT) words_popped++;
        endcase
        owed_results.push_back(want);
      end
      // a capacity written at this edge only applies from the next word on
      if (cfg_wr_en) capacity = cfg_wr_data;
    end
    owed <= owed_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// top of the circular deque testbench: clock, reset, stimulus, result sink and verdict
`timescale 1ns / 1ps
module tb_top;
  import cde_pkg::*;

  localparam int PHASES     = 12;
  localparam int PHASE_OPS  = 50;
  // capacity walk: both extremes, the out-of-range codes and a spread in between
  localparam logic [CAP_W-1:0] CAP_WALK [PHASES] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd3, 5'd16, 5'd5, 5'd1, 5'd12
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  cde_in_if  in_ch ();
  cde_out_if out_ch ();

  int mismatches;
  int owed;
  int words_checked;
  int words_popped;
  int full_refusals;
  int empty_refusals;

  // calm phases run with no gaps on either side
  bit calm;

  circular_deque dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  cde_checker watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatches     (mismatches),
    .owed           (owed),
    .words_checked  (words_checked),
    .words_popped   (words_popped),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles before the next word: none in calm phases or half the time, else a random nonzero gap
  function automatic int pick_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // mostly random words, with the all-zero and all-one extremes mixed in
  function automatic logic [FIELD_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // push_bias in percent steers a phase towards full or towards empty
  function automatic op_t pick_op(int push_bias);
    bit left_side;
    left_side = $urandom_range(0, 1);
    if ($urandom_range(0, 99) < push_bias) return left_side ? OP_PUSH_LEFT : OP_PUSH_RIGHT;
    return left_side ? OP_POP_LEFT : OP_POP_RIGHT;
  endfunction

  // present one word and hold it until taken; valid stays high on return so a
  // back-to-back word needs only the one assignment in the next call
  task automatic send_op(op_t op, logic [FIELD_BITS-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.push_word <= word;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // drop valid and hold off until every owed result has left
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: stall a drawn number of cycles, then take one word
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : stimulus
    int bias;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= CAP_RESET;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_PUSH_LEFT;
    in_ch.push_word <= '0;
    calm            = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset capacity of 16
    // pops on the empty deque are refused and read nothing
    send_op(OP_POP_LEFT, 32'hFFFF_FFFF);
    send_op(OP_POP_RIGHT, 32'hFFFF_FFFF);
    // sixteen pushes fill every cell, so no later read can hit an unwritten one;
    // the first lands in cell zero, left pushes then wrap down from the top
    send_op(OP_PUSH_RIGHT, 32'h0000_0000);
    send_op(OP_PUSH_LEFT,  32'hFFFF_FFFF);
    send_op(OP_PUSH_RIGHT, 32'hAAAA_AAAA);
    send_op(OP_PUSH_LEFT,  32'h5555_5555);
    send_op(OP_PUSH_RIGHT, 32'h8000_0000);
    send_op(OP_PUSH_LEFT,  32'h0000_0001);
    send_op(OP_PUSH_RIGHT, 32'h7FFF_FFFF);
    send_op(OP_PUSH_LEFT,  32'hFFFF_FFFE);
    repeat (4) begin
      send_op(OP_PUSH_RIGHT, pick_word());
      send_op(OP_PUSH_LEFT, pick_word());
    end
    // full now: pushes at either end are refused
    send_op(OP_PUSH_LEFT, 32'h1234_5678);
    send_op(OP_PUSH_RIGHT, 32'h9ABC_DEF0);
    send_op(OP_POP_LEFT, '0);
    send_op(OP_POP_RIGHT, '0);
    send_op(OP_POP_LEFT, '0);

    // random phases; the deque keeps its words across each capacity change,
    // and the sender waits out every owed result before the write
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_capacity(CAP_WALK[p]);
      calm = (p % 3 == 2);
      case ($urandom_range(0, 3))
        0:       bias = 20;
        1:       bias = 50;
        2:       bias = 70;
        default: bias = 85;
      endcase
      repeat (PHASE_OPS) send_op(pick_op(bias), pick_word());
    end

    settle();
    repeat (4) @(posedge clk);
    $display("checked %0d results: %0d words popped, %0d pushes refused as full, %0d pops refused as empty",
             words_checked, words_popped, full_refusals, empty_refusals);
    $display("capacity walked through %0d settings, 0 and 31 (out of range) among them", PHASES);
    if (mismatches == 0 && owed == 0) begin
      $display("circular_deque: match");
    end else begin
      $display("circular_deque: mismatch");
    end
    $finish;
  end

  // generous ceiling, many times the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("circular_deque: mismatch");
    $finish;
  end

endmodule
